### hw/rtl/rpad_pkg.sv
// ----------------------------------------------------------------------------
// rpad_pkg
// Shared types and constants of the rational to p-adic digit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpad_pkg;

  localparam int DEF_MAX_DIGITS = 64;
  localparam int WORD_W         = 32;
  localparam int P_W            = 7;
  localparam int DC_W           = 7;
  localparam int VAL_W          = 6;
  localparam int C_W            = 34;
  localparam int DIV_W          = 40;
  localparam int DIV_CELLS      = 8;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ZNUM  = 2'd1;
  localparam logic [1:0] STATUS_ZDEN  = 2'd2;

  localparam logic REG_PRIME       = 1'b0;
  localparam logic REG_DIGIT_COUNT = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quo;
    logic [P_W-1:0]          rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/rpad_cell.sv
// ----------------------------------------------------------------------------
// rpad_cell
// One restoring long-division step by the base: shifts in one dividend bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpad_cell import rpad_pkg::*; (
  input  wire logic [P_W-1:0] p,
  input  wire logic [P_W-1:0] rem_in,
  input  wire logic           bit_in,
  output logic [P_W-1:0]      rem_out,
  output logic                q
);

  logic [P_W:0] t;
  logic [P_W:0] t_sub;

  assign t     = {rem_in, bit_in};
  assign t_sub = t - {1'b0, p};
  assign q     = (t >= {1'b0, p});
  assign rem_out = q ? t_sub[P_W-1:0] : t[P_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/rpad_div.sv
// ----------------------------------------------------------------------------
// rpad_div
// Floor division of a signed word by the base over a row of division cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rpad_div import rpad_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [P_W-1:0] p,
  input  wire div_req_t       req,
  output div_rsp_t            rsp
);

  localparam int STEPS = DIV_W / DIV_CELLS;
  localparam int SW    = $clog2(STEPS + 1);

  logic                    busy;
  logic                    fin;
  logic                    done;
  logic [SW-1:0]           step;
  logic [DIV_W-1:0]        mag;
  logic [P_W-1:0]          rem;
  logic                    neg;
  logic [P_W-1:0]          p_q;
  logic signed [DIV_W-1:0] quo;
  logic [P_W-1:0]          rem_res;
  logic [DIV_W-1:0]        neg_div;

  logic [P_W-1:0]       chain [DIV_CELLS+1];
  logic [DIV_CELLS-1:0] qb;

  assign chain[0] = rem;
  assign neg_div  = DIV_W'(-req.dividend);

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    rpad_cell u_cell (
      .p      (p_q),
      .rem_in (chain[i]),
      .bit_in (mag[DIV_W-1-i]),
      .rem_out(chain[i+1]),
      .q      (qb[DIV_CELLS-1-i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        step <= '0;
        neg  <= req.dividend[DIV_W-1];
        mag  <= req.dividend[DIV_W-1] ? neg_div : req.dividend;
        rem  <= '0;
        p_q  <= p;
      end else if (busy) begin
        mag <= {mag[DIV_W-DIV_CELLS-1:0], qb};
        rem <= chain[DIV_CELLS];
        if (step == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          step <= step + SW'(1);
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        // floor rounding for negative dividends
        if (neg && rem != '0) begin
          quo     <= ~mag;
          rem_res <= p_q - rem;
        end else if (neg) begin
          quo     <= -mag;
          rem_res <= rem;
        end else begin
          quo     <= mag;
          rem_res <= rem;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem_res;

endmodule

`default_nettype wire

### hw/rtl/rational_to_p_adic_digits_unit.sv
// ----------------------------------------------------------------------------
// rational_to_p_adic_digits_unit
// Expands a signed fraction into its p-adic digits for a configured base.
// ----------------------------------------------------------------------------
// One fraction is worked at a time. Every division by the base goes through a
// shared divider built as a row of eight long-division cells, with setup before
// the cell steps and rounding after them. An item first strips the factors of
// the base from numerator and denominator (vn, vd the factors of the base
// removed from numerator and denominator), then runs the inverse search over k
// up to p-1, then per digit two divisions for the digit, one multiply and one
// division for the update, plus any output stall. A zero numerator or
// denominator gives one status request.
`default_nettype none

module rational_to_p_adic_digits_unit import rpad_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [DC_W-1:0]          cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [WORD_W-1:0] numerator,
  input  wire logic signed [WORD_W-1:0] denominator,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [P_W-1:0]                digit,
  output logic signed [VAL_W-1:0]      valuation,
  output logic [1:0]                    status,
  output logic                          last_digit
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SPEC, S_STRIPC, S_STRIPD, S_INV, S_MODC, S_MODP,
    S_MUL, S_SUB, S_DIVC, S_EMIT
  } state_t;

  state_t                   state;
  logic [P_W-1:0]           prime_r;
  logic [DC_W-1:0]          digit_count_r;
  logic [P_W-1:0]           p_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         done_cnt;
  logic signed [C_W-1:0]    c_q;
  logic signed [WORD_W-1:0] d_q;
  logic [P_W-1:0]           dm_q;
  logic [P_W-1:0]           acc;
  logic [P_W-1:0]           k;
  logic [P_W-1:0]           inv_q;
  logic [P_W-1:0]           dg_q;
  logic signed [VAL_W-1:0]  val_q;
  logic [1:0]               spec_status;
  logic signed [DIV_W-1:0]  prod_q;

  logic [P_W-1:0]           p_eff;
  logic [CNT_W-1:0]         cnt_eff;
  logic [P_W-1:0]           p_div;
  logic                     slot_free;
  logic                     emit_now;
  logic                     last;
  logic [P_W:0]             acc_sum;
  logic [2*P_W-1:0]         rprod;
  logic signed [DIV_W-1:0]  mul_w;
  logic signed [DIV_W-1:0]  diff;
  logic                     inv_end;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign p_eff = (prime_r < P_W'(2)) ? P_W'(2) : prime_r;

  always_comb begin
    if (digit_count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (digit_count_r > DC_W'(MAX_DIGITS)) begin
      cnt_eff = CNT_W'(MAX_DIGITS);
    end else begin
      cnt_eff = CNT_W'(digit_count_r);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign emit_now  = slot_free && (state == S_SPEC || state == S_EMIT);
  assign last      = (done_cnt == cnt_q - CNT_W'(1));
  assign p_div     = (state == S_IDLE) ? p_eff : p_q;
  assign acc_sum   = {1'b0, acc} + {1'b0, dm_q};
  assign rprod     = div_rsp.rem * inv_q;
  assign mul_w     = d_q * $signed({1'b0, dg_q});
  assign diff      = c_q - prod_q;
  assign inv_end   = (acc == P_W'(1)) || (k == p_q - P_W'(1));

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(c_q);
    unique case (state)
      S_IDLE: begin
        div_req.start    = in_valid && denominator != '0 && numerator != '0;
        div_req.dividend = DIV_W'(numerator);
      end
      S_STRIPC: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = (div_rsp.rem == '0) ? div_rsp.quo : DIV_W'(d_q);
      end
      S_STRIPD: begin
        div_req.start    = div_rsp.done && div_rsp.rem == '0;
        div_req.dividend = div_rsp.quo;
      end
      S_INV: begin
        div_req.start = inv_end;
      end
      S_MODC: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(rprod);
      end
      S_SUB: begin
        div_req.start    = 1'b1;
        div_req.dividend = diff;
      end
      S_EMIT: begin
        div_req.start = slot_free && !last;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  rpad_div u_div (
    .clk(clk),
    .rst(rst),
    .p  (p_div),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prime_r       <= P_W'(2);
      digit_count_r <= DC_W'(16);
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRIME:       prime_r       <= cfg_data;
          REG_DIGIT_COUNT: digit_count_r <= cfg_data;
          default:         prime_r       <= prime_r;
        endcase
      end
      out_valid <= emit_now || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p_q      <= p_eff;
            cnt_q    <= cnt_eff;
            done_cnt <= '0;
            val_q    <= '0;
            c_q      <= C_W'(numerator);
            d_q      <= denominator;
            if (denominator == '0) begin
              spec_status <= STATUS_ZDEN;
              state       <= S_SPEC;
            end else if (numerator == '0) begin
              spec_status <= STATUS_ZNUM;
              state       <= S_SPEC;
            end else begin
              state <= S_STRIPC;
            end
          end
        end
        S_SPEC: begin
          if (slot_free) begin
            digit      <= '0;
            valuation  <= '0;
            status     <= spec_status;
            last_digit <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_STRIPC: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              c_q   <= div_rsp.quo[C_W-1:0];
              val_q <= val_q + VAL_W'(1);
            end else begin
              state <= S_STRIPD;
            end
          end
        end
        S_STRIPD: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              d_q   <= div_rsp.quo[WORD_W-1:0];
              val_q <= val_q - VAL_W'(1);
            end else begin
              dm_q  <= div_rsp.rem;
              acc   <= div_rsp.rem;
              k     <= P_W'(1);
              state <= S_INV;
            end
          end
        end
        S_INV: begin
          // running acc = dm*k mod p, first k hitting one is the inverse
          if (acc == P_W'(1)) begin
            inv_q <= k;
            state <= S_MODC;
          end else if (inv_end) begin
            inv_q <= '0;
            state <= S_MODC;
          end else begin
            acc <= (acc_sum >= {1'b0, p_q}) ? P_W'(acc_sum - {1'b0, p_q})
                                            : acc_sum[P_W-1:0];
            k   <= k + P_W'(1);
          end
        end
        S_MODC: begin
          if (div_rsp.done) begin
            state <= S_MODP;
          end
        end
        S_MODP: begin
          if (div_rsp.done) begin
            dg_q  <= div_rsp.rem;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= mul_w;
          state  <= S_SUB;
        end
        S_SUB: begin
          state <= S_DIVC;
        end
        S_DIVC: begin
          if (div_rsp.done) begin
            c_q   <= div_rsp.quo[C_W-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            digit      <= dg_q;
            valuation  <= val_q;
            status     <= STATUS_OK;
            last_digit <= last;
            done_cnt   <= done_cnt + CNT_W'(1);
            state      <= last ? S_IDLE : S_MODC;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rpad_checker.sv
// ----------------------------------------------------------------------------
// rpad_checker
// Port-level checks of the rational to p-adic digit unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpad_checker import rpad_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     cfg_we,
  input wire logic                     cfg_index,
  input wire logic [DC_W-1:0]          cfg_data,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [P_W-1:0]           digit,
  input wire logic signed [VAL_W-1:0]  valuation,
  input wire logic [1:0]               status,
  input wire logic                     last_digit
);

  logic [P_W-1:0] p_seen;
  logic [P_W-1:0] p_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_seen <= P_W'(2);
    end else if (cfg_we && cfg_index == REG_PRIME) begin
      p_seen <= cfg_data;
    end
  end

  assign p_use = (p_seen < P_W'(2)) ? P_W'(2) : p_seen;

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> last_digit && digit == '0 && valuation == '0)
    else $error("status request not a lone zero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_OK || status == STATUS_ZNUM || status == STATUS_ZDEN)
    else $error("bad status code");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> digit < p_use)
    else $error("digit not below base");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit) && $stable(last_digit))
    else $error("stalled result changed");

  // one fraction at a time: accepting a request closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a request");

endmodule

bind rational_to_p_adic_digits_unit rpad_checker u_rpad_checker (.*);

`default_nettype wire
